// ----- design/assert_macros.svh -----
// assertion macros shared by the port group controller
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- design/dppi_pkg.sv -----
// types and constants for the dual ppi port group controller
// no dependencies
package dppi_pkg;

	// grouping modes of one port group
	typedef enum logic [1:0] {
		MODE_3X8  = 2'd0,
		MODE_2X12 = 2'd1,
		MODE_1X24 = 2'd2,
		MODE_16P8 = 2'd3
	} mode_t;

	// request commands
	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// configuration register indexes
	localparam logic [1:0] CFG_MODE_GROUP0 = 2'd0;
	localparam logic [1:0] CFG_MODE_GROUP1 = 2'd1;

	// direction bits, set means input
	localparam int DIR_A  = 0;
	localparam int DIR_B  = 1;
	localparam int DIR_CU = 2;
	localparam int DIR_CL = 3;
	localparam logic [3:0] DIR_ALL = 4'hF;

	// control word pieces
	localparam logic [7:0] CW_MODE0 = 8'h80;
	localparam logic [7:0] CW_A_IN  = 8'h10;
	localparam logic [7:0] CW_B_IN  = 8'h02;
	localparam logic [7:0] CW_CU_IN = 8'h04;
	localparam logic [7:0] CW_CL_IN = 8'h01;

	typedef logic [3:0] dir_t;
	typedef logic [2:0][7:0] latch_t;

	typedef struct packed {
		logic        command;
		logic        group_sel;
		logic [1:0]  channel;
		logic [23:0] write_value;
		logic [7:0]  pins_a;
		logic [7:0]  pins_b;
		logic [7:0]  pins_c;
	} req_t;

	typedef struct packed {
		logic        status;
		logic [23:0] read_value;
		logic [7:0]  drive_a;
		logic [7:0]  drive_b;
		logic [7:0]  drive_c;
		logic [7:0]  control_word;
		logic        control_written;
	} rsp_t;

endpackage

// ----- design/dppi_if.sv -----
// request and response channel interfaces for the port group controller
// no dependencies
interface dppi_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic        group_sel;
	logic [1:0]  channel;
	logic [23:0] write_value;
	logic [7:0]  pins_a;
	logic [7:0]  pins_b;
	logic [7:0]  pins_c;

	modport source (output valid, command, group_sel, channel, write_value,
		pins_a, pins_b, pins_c, input ready);
	modport sink (input valid, command, group_sel, channel, write_value,
		pins_a, pins_b, pins_c, output ready);
endinterface

interface dppi_out_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [23:0] read_value;
	logic [7:0]  drive_a;
	logic [7:0]  drive_b;
	logic [7:0]  drive_c;
	logic [7:0]  control_word;
	logic        control_written;

	modport source (output valid, status, read_value, drive_a, drive_b, drive_c,
		control_word, control_written, input ready);
	modport sink (input valid, status, read_value, drive_a, drive_b, drive_c,
		control_word, control_written, output ready);
endinterface

// ----- design/dual_ppi_port_mode_controller_core.sv -----
// Dual mode-0 parallel port group controller. Each request reads or writes one
// channel of group 0 or 1 under that group's grouping mode (3x8, 2x12, 1x24,
// 16+8) and returns one response with status, read value, latched port bytes,
// control word and a flag when port directions changed. Requests are taken
// into an input register and move through the access logic into the
// response register, one request per clock while responses are accepted;
// the input is held off only while a response waits and the input register
// also holds a request. Grouping modes are written through the cfg port;
// the user must do so only while idle, the block itself does not enforce it.
// Depends on dppi_pkg, dppi_if.sv, dppi_access and assert_macros.svh.
module dual_ppi_port_mode_controller_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [1:0]        cfg_data,
	dppi_in_if.sink           in_ch,
	dppi_out_if.source        out_ch
);
	import dppi_pkg::*;

	`include "assert_macros.svh"

	mode_t            mode_q [2];
	dir_t   [1:0]     dir_q;
	latch_t [1:0]     latch_q;

	req_t   req_s1;
	logic   valid_s1;
	rsp_t   rsp_s2;
	logic   valid_s2;
	logic   advance;

	dir_t   dir_nxt;
	latch_t lat_nxt;
	rsp_t   rsp_nxt;

	// stage 1 moves on when the response register is free or being drained
	assign advance     = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q[0] <= MODE_1X24;
			mode_q[1] <= MODE_1X24;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE_GROUP0: mode_q[0] <= mode_t'(cfg_data);
				CFG_MODE_GROUP1: mode_q[1] <= mode_t'(cfg_data);
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			req_s1.command     <= in_ch.command;
			req_s1.group_sel   <= in_ch.group_sel;
			req_s1.channel     <= in_ch.channel;
			req_s1.write_value <= in_ch.write_value;
			req_s1.pins_a      <= in_ch.pins_a;
			req_s1.pins_b      <= in_ch.pins_b;
			req_s1.pins_c      <= in_ch.pins_c;
		end
	end

	// access logic for the addressed group
	dppi_access u_access (
		.req     (req_s1),
		.mode    (mode_q[req_s1.group_sel]),
		.dir_cur (dir_q[req_s1.group_sel]),
		.lat_cur (latch_q[req_s1.group_sel]),
		.dir_nxt (dir_nxt),
		.lat_nxt (lat_nxt),
		.rsp     (rsp_nxt)
	);

	// group state updates when a request leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q   <= {DIR_ALL, DIR_ALL};
			latch_q <= '0;
		end else if (advance) begin
			dir_q[req_s1.group_sel]   <= dir_nxt;
			latch_q[req_s1.group_sel] <= lat_nxt;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= rsp_nxt;
		end
	end

	assign out_ch.valid           = valid_s2;
	assign out_ch.status          = rsp_s2.status;
	assign out_ch.read_value      = rsp_s2.read_value;
	assign out_ch.drive_a         = rsp_s2.drive_a;
	assign out_ch.drive_b         = rsp_s2.drive_b;
	assign out_ch.drive_c         = rsp_s2.drive_c;
	assign out_ch.control_word    = rsp_s2.control_word;
	assign out_ch.control_written = rsp_s2.control_written;

	// checks
	`ASSERT_IMPLY(a_err_no_effect, clk, arst_n, valid_s2 && rsp_s2.status,
		!rsp_s2.control_written && rsp_s2.read_value == 24'h0,
		"rejected request changed state or returned data")
	`ASSERT_IMPLY(a_ready_only_when_blocked, clk, arst_n, !in_ch.ready,
		valid_s1 && valid_s2 && !out_ch.ready,
		"input stalled without a blocked response")
	`ASSERT_NEXT(a_s1_held, clk, arst_n, valid_s1 && !advance,
		valid_s1 && $stable(req_s1), "stage 1 request lost while stalled")
	`ASSERT_ALWAYS(a_cw_mode_bit, clk, arst_n, !valid_s2 || rsp_s2.control_word[7],
		"control word without mode set flag")

endmodule

// ----- design/dppi_access.sv -----
// combinational access logic for one port group: channel check, latch
// update, direction update, read assembly and response; depends on dppi_pkg
module dppi_access (
	input  dppi_pkg::req_t   req,
	input  dppi_pkg::mode_t  mode,
	input  dppi_pkg::dir_t   dir_cur,
	input  dppi_pkg::latch_t lat_cur,
	output dppi_pkg::dir_t   dir_nxt,
	output dppi_pkg::latch_t lat_nxt,
	output dppi_pkg::rsp_t   rsp
);
	import dppi_pkg::*;

	logic        chan_ok;
	dir_t        chan_mask;
	logic [23:0] rd_val;
	logic        is_ch0;
	logic        is_ch1;

	assign is_ch0 = (req.channel == 2'd0);
	assign is_ch1 = (req.channel == 2'd1);

	// channel check and direction mask per grouping
	always_comb begin
		chan_ok   = 1'b0;
		chan_mask = '0;
		unique case (mode)
			MODE_3X8: begin
				chan_ok = (req.channel != 2'd3);
				if (is_ch0) begin
					chan_mask[DIR_A] = 1'b1;
				end else if (is_ch1) begin
					chan_mask[DIR_B] = 1'b1;
				end else begin
					chan_mask[DIR_CU] = 1'b1;
					chan_mask[DIR_CL] = 1'b1;
				end
			end
			MODE_2X12: begin
				chan_ok = is_ch0 || is_ch1;
				if (is_ch0) begin
					chan_mask[DIR_A]  = 1'b1;
					chan_mask[DIR_CU] = 1'b1;
				end else begin
					chan_mask[DIR_B]  = 1'b1;
					chan_mask[DIR_CL] = 1'b1;
				end
			end
			MODE_1X24: begin
				chan_ok   = is_ch0;
				chan_mask = DIR_ALL;
			end
			MODE_16P8: begin
				chan_ok = is_ch0 || is_ch1;
				if (is_ch0) begin
					chan_mask[DIR_A] = 1'b1;
					chan_mask[DIR_B] = 1'b1;
				end else begin
					chan_mask[DIR_CU] = 1'b1;
					chan_mask[DIR_CL] = 1'b1;
				end
			end
			default: begin
				chan_ok   = 1'b0;
				chan_mask = '0;
			end
		endcase
	end

	// latch update for writes
	always_comb begin
		lat_nxt = lat_cur;
		if (chan_ok && req.command == CMD_WRITE) begin
			unique case (mode)
				MODE_3X8: begin
					lat_nxt[req.channel] = req.write_value[7:0];
				end
				MODE_2X12: begin
					if (is_ch0) begin
						lat_nxt[0]      = req.write_value[7:0];
						lat_nxt[2][7:4] = req.write_value[11:8];
					end else begin
						lat_nxt[1]      = req.write_value[7:0];
						lat_nxt[2][3:0] = req.write_value[11:8];
					end
				end
				MODE_1X24: begin
					lat_nxt[0] = req.write_value[7:0];
					lat_nxt[1] = req.write_value[15:8];
					lat_nxt[2] = req.write_value[23:16];
				end
				MODE_16P8: begin
					if (is_ch0) begin
						lat_nxt[0] = req.write_value[7:0];
						lat_nxt[1] = req.write_value[15:8];
					end else begin
						lat_nxt[2] = req.write_value[7:0];
					end
				end
				default: begin
					lat_nxt = lat_cur;
				end
			endcase
		end
	end

	// read value assembly from sampled pins
	always_comb begin
		rd_val = '0;
		if (chan_ok && req.command == CMD_READ) begin
			unique case (mode)
				MODE_3X8: begin
					if (is_ch0) begin
						rd_val = {16'h0, req.pins_a};
					end else if (is_ch1) begin
						rd_val = {16'h0, req.pins_b};
					end else begin
						rd_val = {16'h0, req.pins_c};
					end
				end
				MODE_2X12: begin
					if (is_ch0) begin
						rd_val = {12'h0, req.pins_c[7:4], req.pins_a};
					end else begin
						rd_val = {12'h0, req.pins_c[3:0], req.pins_b};
					end
				end
				MODE_1X24: begin
					rd_val = {req.pins_c, req.pins_b, req.pins_a};
				end
				MODE_16P8: begin
					if (is_ch0) begin
						rd_val = {8'h0, req.pins_b, req.pins_a};
					end else begin
						rd_val = {16'h0, req.pins_c};
					end
				end
				default: begin
					rd_val = '0;
				end
			endcase
		end
	end

	// direction update for valid channels: writes clear input bits, reads set them
	always_comb begin
		dir_nxt = dir_cur;
		if (chan_ok) begin
			if (req.command == CMD_WRITE) begin
				dir_nxt = dir_cur & ~chan_mask;
			end else begin
				dir_nxt = dir_cur | chan_mask;
			end
		end
	end

	// response fields
	always_comb begin
		rsp.status          = ~chan_ok;
		rsp.read_value      = rd_val;
		rsp.drive_a         = lat_nxt[0];
		rsp.drive_b         = lat_nxt[1];
		rsp.drive_c         = lat_nxt[2];
		rsp.control_word    = CW_MODE0
			| (dir_nxt[DIR_A]  ? CW_A_IN  : 8'h00)
			| (dir_nxt[DIR_B]  ? CW_B_IN  : 8'h00)
			| (dir_nxt[DIR_CU] ? CW_CU_IN : 8'h00)
			| (dir_nxt[DIR_CL] ? CW_CL_IN : 8'h00);
		rsp.control_written = (dir_nxt != dir_cur);
	end

endmodule
